// File: hw/rtl/acra_pkg.sv
`default_nettype none

package acra_pkg;

    // fixed field widths
    localparam int OP_W      = 3;
    localparam int IDX_W     = 6;
    localparam int KIND_W    = 3;
    localparam int ST_W      = 3;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_ACT_ANY  = 3'd0;
    localparam logic [OP_W-1:0] OP_ACT_AT   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_FREEZE   = 3'd3;
    localparam logic [OP_W-1:0] OP_QRY_CONS = 3'd4;
    localparam logic [OP_W-1:0] OP_QRY_ROW  = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_CBUSY    = 3'd1;
    localparam logic [ST_W-1:0] ST_RBUSY    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOFREE   = 3'd3;
    localparam logic [ST_W-1:0] ST_INACTIVE = 3'd4;
    localparam logic [ST_W-1:0] ST_FROZEN   = 3'd5;
    localparam logic [ST_W-1:0] ST_BADKIND  = 3'd6;

    // bound kinds
    localparam logic [KIND_W-1:0] K_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] K_LOWER  = 3'd1;
    localparam logic [KIND_W-1:0] K_UPPER  = 3'd2;
    localparam logic [KIND_W-1:0] K_DOUBLE = 3'd3;
    localparam logic [KIND_W-1:0] K_TWIN   = 3'd4;

    // bound history, same code points as the kinds that it can hold
    localparam logic [1:0] H_NONE   = 2'd0;
    localparam logic [1:0] H_LOWER  = 2'd1;
    localparam logic [1:0] H_UPPER  = 2'd2;
    localparam logic [1:0] H_DOUBLE = 2'd3;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_OWN,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/active_constraint_row_allocator_unit.sv
// Active-set row allocator: two-way map between constraints and working rows.
//
// Input stream (s_axis): one beat carries one operation (tuser) with its
// constraint index, bound kind and row index (tdata). Output stream (m_axis):
// exactly one result beat per input beat, status in tuser, fields in tdata.
//
// Steps per beat, from accept to the final step, in which the result
// register loads and the block returns to idle:
//   activate at row, freeze, constraint query, unused code : final step
//   release, row query                                     : owner lookup
//   activate at lowest free row : scan from row 0, which reads the row table
//     one entry per cycle and ends at a free row, at the last row or when full
//   clear                        : sweep, one table entry wiped a cycle
// The block takes one beat at a time; tready is high only while idle.
//
// Reset starts the same sweep as clear, with tready low and no
// result beat. A result waits in the output register while the receiver
// stalls; the next beat is still accepted and runs up to its final step,
// which holds until the output register is free.
`default_nettype none

module active_constraint_row_allocator_unit
    import acra_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [5:0] constraint_index, [8:6] bound_kind, [14:9] row_index, [15] zero
    input  wire [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] operation
    input  wire [OP_W-1:0]       i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // [5:0] row_out, [11:6] constraint_out, [14:12] kind_out, [15] is_active,
    // [16] is_frozen, [17] was_lower, [18] was_upper, [19] row_is_free,
    // [26:20] active_count, [31:27] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] status
    output logic [ST_W-1:0]      o_m_axis_tuser
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // constraint table entry and row table entry
    typedef struct packed {
        logic              frz;
        logic [1:0]        hist;
        logic [KIND_W-1:0] kind;
        logic [IW-1:0]     row;
    } t_centry;

    typedef struct packed {
        logic          used;
        logic [IW-1:0] owner;
    } t_rentry;

    // ---------------------------------------------------------------------
    // Control and payload registers
    // ---------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [IW-1:0]        r_clr_addr, n_clr_addr;
    logic                 r_clr_reply, n_clr_reply;
    logic [CW-1:0]        r_used, n_used;
    logic                 r_afree, n_afree;
    logic                 r_m_tvalid, n_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [ST_W-1:0]      r_m_tuser, n_m_tuser;

    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_ref;
    logic [KIND_W-1:0]    r_kind;
    logic [IDX_W-1:0]     r_row;
    logic [IW-1:0]        r_cadr, n_cadr;  // constraint table read address
    logic [IW-1:0]        r_radr, n_radr;  // row table read address
    logic [IW-1:0]        r_arow, n_arow;  // row an activation targets

    // tables, read data registered
    t_centry cmem [ENTRIES];
    t_rentry rmem [ENTRIES];
    t_centry r_crd;
    t_rentry r_rrd;

    logic          c_we, r_we;
    logic [IW-1:0] c_wa, r_wa;
    t_centry       c_wd;
    t_rentry       r_wd;

    // input side
    logic          s_acc;
    logic          out_free;
    logic [IW-1:0] in_ref_a, in_row_a;
    logic [IW-1:0] ref_a, row_a;
    logic          ref_ok, row_ok;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_tvalid || i_m_axis_tready;

    assign in_ref_a = IW'(i_s_axis_tdata[5:0]);
    assign in_row_a = IW'(i_s_axis_tdata[14:9]);
    assign ref_a    = IW'(r_ref);
    assign row_a    = IW'(r_row);
    assign ref_ok   = (32'(r_ref) < 32'(ENTRIES));
    assign row_ok   = (32'(r_row) < 32'(ENTRIES));

    // ---------------------------------------------------------------------
    // Final step of an operation: checks, table updates, result fields.
    // Tables hold the subject constraint (r_crd) and row_index (r_rrd).
    // ---------------------------------------------------------------------
    logic [ST_W-1:0]      x_status;
    logic                 x_subj;
    logic [IW-1:0]        x_cons;
    t_centry              pc;          // subject entry after the operation
    logic                 x_cw, x_rw;
    logic [IW-1:0]        x_ca, x_ra;
    t_rentry              x_rd;
    logic [CW-1:0]        x_used;
    logic                 x_rowused;   // row_index in use after the operation
    logic                 act_free;
    logic                 p_act;
    logic [M_TDATA_W-1:0] x_tdata;

    always_comb begin
        x_status  = ST_OK;
        x_subj    = 1'b0;
        x_cons    = '0;
        pc        = r_crd;
        x_cw      = 1'b0;
        x_ca      = ref_a;
        x_rw      = 1'b0;
        x_ra      = row_a;
        x_rd      = '0;
        x_used    = r_used;
        x_rowused = r_rrd.used;
        act_free  = (r_op == OP_ACT_ANY) ? r_afree : (row_ok && !r_rrd.used);

        unique case (r_op)
            OP_ACT_ANY, OP_ACT_AT: begin
                x_subj = ref_ok;
                if (r_op == OP_ACT_ANY && !r_afree) begin
                    x_status = ST_NOFREE;
                end else if (!ref_ok) begin
                    x_status = ST_INACTIVE;
                end else if (r_crd.kind != K_NONE) begin
                    x_status = ST_CBUSY;
                end else if (!act_free) begin
                    x_status = ST_RBUSY;
                end else if (r_kind == K_NONE || r_kind > K_TWIN) begin
                    x_status = ST_BADKIND;
                end else if (r_crd.hist != H_NONE && r_kind != K_LOWER
                             && r_kind != K_UPPER) begin
                    // a constraint with history comes back on one side only
                    x_status = ST_BADKIND;
                end else begin
                    pc.kind = r_kind;
                    pc.row  = r_arow;
                    if (r_crd.hist == H_NONE) begin
                        pc.hist = (r_kind == K_TWIN) ? H_NONE : r_kind[1:0];
                    end else begin
                        pc.hist = H_DOUBLE;
                    end
                    x_cw   = 1'b1;
                    x_rw   = 1'b1;
                    x_ra   = r_arow;
                    x_rd   = '{used: 1'b1, owner: ref_a};
                    x_used = r_used + 1'b1;
                    if (row_ok && r_arow == row_a) begin
                        x_rowused = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                if (!row_ok || !r_rrd.used || r_crd.kind == K_NONE) begin
                    x_status = ST_INACTIVE;
                end else begin
                    // freeze flag and history survive the release
                    x_subj    = 1'b1;
                    x_cons    = r_rrd.owner;
                    pc.kind   = K_NONE;
                    pc.row    = '0;
                    x_cw      = 1'b1;
                    x_ca      = r_rrd.owner;
                    x_rw      = 1'b1;
                    x_rd      = '0;
                    x_used    = (r_used != '0) ? r_used - 1'b1 : r_used;
                    x_rowused = 1'b0;
                end
            end
            OP_FREEZE: begin
                x_subj = ref_ok;
                if (!ref_ok || r_crd.kind == K_NONE) begin
                    x_status = ST_INACTIVE;
                end else if (r_crd.kind == K_TWIN || r_crd.frz) begin
                    x_status = ST_FROZEN;
                end else begin
                    pc.frz = 1'b1;
                    x_cw   = 1'b1;
                end
            end
            OP_QRY_CONS: begin
                x_subj = ref_ok;
                if (!ref_ok) begin
                    x_status = ST_INACTIVE;
                end
            end
            OP_QRY_ROW: begin
                if (!row_ok || !r_rrd.used) begin
                    x_status = ST_INACTIVE;
                end else begin
                    x_subj = 1'b1;
                    x_cons = r_rrd.owner;
                end
            end
            default: begin
                // unused code: reported as a constraint query, nothing changes
                x_subj = ref_ok;
            end
        endcase

        p_act   = x_subj && (pc.kind != K_NONE);
        x_tdata = M_TDATA_W'({
            CNT_W'(x_used),
            row_ok && !x_rowused,
            x_subj && (pc.hist == H_UPPER || pc.hist == H_DOUBLE),
            x_subj && (pc.hist == H_LOWER || pc.hist == H_DOUBLE),
            x_subj && (pc.frz || pc.kind == K_TWIN),
            p_act,
            x_subj ? pc.kind : K_NONE,
            IDX_W'(x_cons),
            p_act ? IDX_W'(pc.row) : IDX_W'(0)
        });
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_used      = r_used;
        n_afree     = r_afree;
        n_cadr      = r_cadr;
        n_radr      = r_radr;
        n_arow      = r_arow;
        n_m_tvalid  = r_m_tvalid && !i_m_axis_tready;
        n_m_tdata   = r_m_tdata;
        n_m_tuser   = r_m_tuser;
        c_we        = 1'b0;
        c_wa        = x_ca;
        c_wd        = pc;
        r_we        = 1'b0;
        r_wa        = x_ra;
        r_wd        = x_rd;

        unique case (r_state)
            S_CLR: begin
                // wipe one entry of each table per cycle
                c_we   = 1'b1;
                c_wa   = r_clr_addr;
                c_wd   = '0;
                r_we   = 1'b1;
                r_wa   = r_clr_addr;
                r_wd   = '0;
                n_used = '0;
                if (r_clr_addr == LAST) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_reply ? S_EXEC : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_cadr  = in_ref_a;
                    n_radr  = (i_s_axis_tuser == OP_ACT_ANY) ? '0 : in_row_a;
                    n_arow  = in_row_a;
                    n_afree = 1'b0;
                    unique case (i_s_axis_tuser)
                        OP_ACT_ANY: begin
                            n_state = S_SCAN;
                        end
                        OP_RELEASE, OP_QRY_ROW: begin
                            n_state = S_OWN;
                        end
                        OP_CLEAR: begin
                            n_state     = S_CLR;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                        end
                        default: begin
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // r_rrd holds the row at r_radr; walk up until a free one
                if (32'(r_used) >= 32'(ENTRIES)) begin
                    n_afree = 1'b0;
                    n_radr  = row_a;
                    n_state = S_EXEC;
                end else if (!r_rrd.used) begin
                    n_afree = 1'b1;
                    n_arow  = r_radr;
                    n_radr  = row_a;
                    n_state = S_EXEC;
                end else if (r_radr == LAST) begin
                    n_afree = 1'b0;
                    n_radr  = row_a;
                    n_state = S_EXEC;
                end else begin
                    n_radr = r_radr + 1'b1;
                end
            end
            S_OWN: begin
                // subject is the owner of row_index
                n_cadr  = r_rrd.owner;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_state    = S_IDLE;
                    if (r_clr_reply) begin
                        n_m_tdata   = '0;
                        n_m_tuser   = ST_OK;
                        n_clr_reply = 1'b0;
                    end else begin
                        n_m_tdata = x_tdata;
                        n_m_tuser = x_status;
                        c_we      = x_cw;
                        r_we      = x_rw;
                        n_used    = x_used;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_used      <= '0;
            r_afree     <= 1'b0;
            r_m_tvalid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_used      <= n_used;
            r_afree     <= n_afree;
            r_m_tvalid  <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op   <= i_s_axis_tuser;
            r_ref  <= i_s_axis_tdata[5:0];
            r_kind <= i_s_axis_tdata[8:6];
            r_row  <= i_s_axis_tdata[14:9];
        end
        r_cadr    <= n_cadr;
        r_radr    <= n_radr;
        r_arow    <= n_arow;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    // tables: read data always matches the registered read address
    always_ff @(posedge i_clk) begin
        if (c_we) begin
            cmem[c_wa] <= c_wd;
        end
        r_crd <= cmem[n_cadr];
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            rmem[r_wa] <= r_wd;
        end
        r_rrd <= rmem[n_radr];
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_used_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(ENTRIES))
        else $error("row count beyond table depth");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("ready straight after an accepted beat");

    a_result_from_exec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_tvalid) |-> $past(r_state) == S_EXEC)
        else $error("result beat raised outside the final step");

endmodule

`default_nettype wire
